FILE: hw/rtl/bffa_pkg.sv
//------------------------------------------------------------------------------
// bffa_pkg: shared types and codes of the bitmap first-fit allocator
// Holds operation and status codes and the item carried from front to back.
//------------------------------------------------------------------------------
`default_nettype none
package bffa_pkg;
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NO_RUN  = 2'd1;
	localparam logic [1:0] ST_BAD_SZ  = 2'd2;
	localparam logic [1:0] ST_BAD_OFF = 2'd3;

	localparam int HDR_BYTES = 4;

	typedef enum logic [1:0] {
		K_REPLY = 2'd0,
		K_ALLOC = 2'd1,
		K_FREE  = 2'd2,
		K_QUERY = 2'd3
	} kind_t;

	// Classified command: start block for free/query, blocks needed for alloc.
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic [16:0] need;
		logic [15:0] start;
	} cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bitmap_first_fit_block_allocator_core.sv
//------------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core: first-fit block heap manager
// Allocates, releases and sizes runs of blocks tracked in a used-bit map.
//------------------------------------------------------------------------------
// Channel | dir | fields
// s_axis  | in  | tdata: opcode[1:0], request_bytes[33:2], payload_offset[53:34]
// m_axis  | out | tdata: status[1:0], result_offset[21:2], payload_bytes[41:22]
//
// An allocation scans one block per cycle, pausing to read each 32-block map
// word, and then marks the run word by word through read, write and length
// states. Release reads the stored length and clears the run word by word the
// same way; query reads the stored length. After reset a clearing pass over
// both memories runs before the engine takes commands from the queue.
// Decoding and a two-entry queue sit in front, so items are taken while the
// engine works or its result waits.
`default_nettype none
module bitmap_first_fit_block_allocator_core
	import bffa_pkg::*;
#(
	parameter int BLOCK_COUNT = 65536,
	parameter int BLOCK_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // opcode, request_bytes, payload_offset
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // status, result_offset, payload_bytes
);
	cmd_t dec, q_cmd;
	logic q_full, q_empty, q_pop;
	logic [1:0]  st;
	logic [19:0] ro, pb;

	bffa_front #(.BLOCK_COUNT(BLOCK_COUNT), .BLOCK_BYTES(BLOCK_BYTES)) u_front (
		.opcode(s_axis_tdata[1:0]), .request_bytes(s_axis_tdata[33:2]),
		.payload_offset(s_axis_tdata[53:34]), .cmd(dec)
	);

	assign s_axis_tready = !q_full;

	bffa_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(s_axis_tvalid), .wdata(dec), .full(q_full),
		.pop(q_pop), .rdata(q_cmd), .empty(q_empty)
	);

	bffa_back #(.BLOCK_COUNT(BLOCK_COUNT), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_status(st),
		.res_offset(ro), .res_payload(pb)
	);

	assign m_axis_tdata = {6'd0, pb, ro, st};

`ifndef SYNTHESIS
	// A result held back must stay stable.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// The queue never pops when empty.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("pop of empty queue");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/bffa_ram.sv
//------------------------------------------------------------------------------
// bffa_ram: generic single-port RAM
// One access a cycle; read data registered, and a write returns the old word.
//------------------------------------------------------------------------------
`default_nettype none
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bffa_front.sv
//------------------------------------------------------------------------------
// bffa_front: command decode and classification
// Checks sizes and offsets, computes block counts and start blocks.
//------------------------------------------------------------------------------
`default_nettype none
module bffa_front
	import bffa_pkg::*;
#(
	parameter int BLOCK_COUNT = 65536,
	parameter int BLOCK_BYTES = 16
) (
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] request_bytes,
	input  wire logic [19:0] payload_offset,
	output cmd_t             cmd
);
	localparam int          BB_LOG = $clog2(BLOCK_BYTES);
	localparam longint      HEAP   = longint'(BLOCK_COUNT) * longint'(BLOCK_BYTES);
	localparam logic [33:0] HEAP34 = 34'(HEAP);
	localparam logic [33:0] BBM1   = 34'(BLOCK_BYTES - 1);

	logic [33:0] total;
	logic [33:0] nblk;
	logic [19:0] rel;
	logic [19:0] sblk;

	// Block sizes are powers of two, so division is a shift.
	always_comb begin
		total = 34'(request_bytes) + 34'(HDR_BYTES);
		nblk  = (total + BBM1) >> BB_LOG;
		rel   = payload_offset - 20'(HDR_BYTES);
		sblk  = rel >> BB_LOG;
		cmd   = '{kind: K_REPLY, status: ST_DONE, need: 17'(nblk), start: 16'(sblk)};
		unique case (opcode)
			OP_ALLOC: begin
				if (request_bytes == 32'd0 || total > HEAP34) cmd.status = ST_BAD_SZ;
				else cmd.kind = K_ALLOC;
			end
			OP_FREE, OP_QUERY: begin
				if (payload_offset < 20'(HDR_BYTES) || 34'(payload_offset) >= HEAP34)
					cmd.status = ST_BAD_OFF;
				else cmd.kind = (opcode == OP_FREE) ? K_FREE : K_QUERY;
			end
			default: cmd.status = ST_BAD_OFF;
		endcase
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bffa_fifo.sv
//------------------------------------------------------------------------------
// bffa_fifo: two-entry command queue
// Decouples decode from execution.
//------------------------------------------------------------------------------
`default_nettype none
module bffa_fifo
	import bffa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);
	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bffa_back.sv
//------------------------------------------------------------------------------
// bffa_back: allocation engine
// Scans the used map word by word, sets and clears runs, reads lengths.
//------------------------------------------------------------------------------
`default_nettype none
module bffa_back
	import bffa_pkg::*;
#(
	parameter int BLOCK_COUNT = 65536,
	parameter int BLOCK_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [1:0]       res_status,
	output logic [19:0]      res_offset,
	output logic [19:0]      res_payload
);
	localparam int WW    = 32;
	localparam int NW    = (BLOCK_COUNT + WW - 1) / WW;
	localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
	localparam int BAW   = $clog2(BLOCK_COUNT);
	localparam int BB_LOG = $clog2(BLOCK_BYTES);
	localparam logic [16:0] BCNT = 17'(BLOCK_COUNT);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN, S_MARK_RD, S_MARK_WR, S_LEN_WR,
		S_FREE_LEN, S_QUERY_LEN, S_OUT
	} state_t;

	state_t      state_q;
	logic [WAW-1:0] wa_q;
	logic [16:0] blk_q;      // current block index during scan/mark
	logic [16:0] cnt_q;      // run length counted so far
	logic [16:0] run_start_q;
	logic [16:0] end_q;
	logic        setv_q;
	cmd_t        c_q;

	logic            map_we, len_we;
	logic [WAW-1:0]  map_addr;
	logic [BAW-1:0]  len_addr;
	logic [WW-1:0]   map_wdata, map_rdata;
	logic [16:0]     len_wdata, len_rdata;
	logic [WW-1:0]   mark_w;

	bffa_ram #(.WIDTH(WW), .DEPTH(NW)) u_map (
		.clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
	);
	bffa_ram #(.WIDTH(17), .DEPTH(BLOCK_COUNT)) u_len (
		.clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wdata), .rdata(len_rdata)
	);

	logic [16:0] blk_nx;
	logic [34:0] pay_w;
	assign blk_nx = blk_q + 17'd1;
	assign pay_w  = (35'(len_rdata) << BB_LOG) - 35'(HDR_BYTES);

	// The bits of the run that fall inside the current map word take the new value.
	always_comb begin
		mark_w = map_rdata;
		for (int k = 0; k < WW; k++) begin
			if (17'(k) >= 17'(blk_q[4:0]) && ({blk_q[16:5], 5'(k)} < end_q))
				mark_w[k] = setv_q;
		end
	end

	always_comb begin
		map_we    = 1'b0;
		len_we    = 1'b0;
		map_addr  = wa_q;
		len_addr  = BAW'(blk_q);
		map_wdata = '0;
		len_wdata = 17'd0;
		unique case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_wdata = '0;
				len_we    = 1'b1;
			end
			S_MARK_WR: begin
				map_we    = 1'b1;
				map_wdata = mark_w;
			end
			S_LEN_WR: begin
				len_we    = setv_q;
				len_addr  = BAW'(run_start_q);
				len_wdata = c_q.need;
			end
			S_IDLE: len_addr = BAW'(cmd.start);
			default: ;
		endcase
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			wa_q      <= '0;
			blk_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			unique case (state_q)
				// One pass over both memories; length words use blk_q too.
				S_CLEAR: begin
					blk_q <= blk_nx;
					wa_q  <= WAW'(blk_nx >> 5);
					if (blk_nx == BCNT) begin
						blk_q   <= '0;
						wa_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						c_q         <= cmd;
						res_status  <= cmd.status;
						res_offset  <= '0;
						res_payload <= '0;
						unique case (cmd.kind)
							K_REPLY: begin
								res_valid <= 1'b1;
								state_q   <= S_OUT;
							end
							K_ALLOC: begin
								blk_q   <= '0;
								cnt_q   <= '0;
								wa_q    <= '0;
								state_q <= S_SCAN_RD;
							end
							K_FREE:  state_q <= S_FREE_LEN;
							K_QUERY: state_q <= S_QUERY_LEN;
						endcase
					end
				end
				S_SCAN_RD: state_q <= S_SCAN;
				// One bit per cycle, pausing in S_SCAN_RD at each new word.
				S_SCAN: begin
					if (map_rdata[blk_q[4:0]]) begin
						cnt_q <= '0;
					end else begin
						if (cnt_q == 17'd0) run_start_q <= blk_q;
						cnt_q <= cnt_q + 17'd1;
						if (cnt_q + 17'd1 == c_q.need) begin
							run_start_q <= (cnt_q == 17'd0) ? blk_q : run_start_q;
							blk_q       <= (cnt_q == 17'd0) ? blk_q : run_start_q;
							end_q       <= blk_nx;
							wa_q        <= WAW'(((cnt_q == 17'd0) ? blk_q : run_start_q) >> 5);
							setv_q      <= 1'b1;
							state_q     <= S_MARK_RD;
						end
					end
					if (!(!map_rdata[blk_q[4:0]] && cnt_q + 17'd1 == c_q.need)) begin
						if (blk_nx == BCNT) begin
							res_status <= ST_NO_RUN;
							res_valid  <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							blk_q <= blk_nx;
							if (blk_nx[4:0] == 5'd0) begin
								wa_q    <= WAW'(blk_nx >> 5);
								state_q <= S_SCAN_RD;
							end
						end
					end
				end
				S_MARK_RD: state_q <= S_MARK_WR;
				// Read-modify-write of one map word: the part of the run inside
				// the word is written back.
				S_MARK_WR: state_q <= S_LEN_WR;
				S_LEN_WR: begin
					blk_q <= {blk_q[16:5] + 12'd1, 5'd0};
					wa_q  <= WAW'(blk_q[16:5] + 12'd1);
					if ({blk_q[16:5] + 12'd1, 5'd0} >= end_q) begin
						if (setv_q) res_offset <= 20'((32'(run_start_q) << BB_LOG)
						                            + 32'(HDR_BYTES));
						res_valid <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_MARK_RD;
					end
				end
				S_FREE_LEN: begin
					blk_q       <= {1'b0, c_q.start};
					run_start_q <= {1'b0, c_q.start};
					wa_q        <= WAW'(c_q.start >> 5);
					end_q       <= (18'(c_q.start) + 18'(len_rdata) > 18'(BCNT)) ? BCNT
					               : 17'(18'(c_q.start) + 18'(len_rdata));
					setv_q      <= 1'b0;
					if (len_rdata == 17'd0) begin
						res_valid <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_MARK_RD;
					end
				end
				S_QUERY_LEN: begin
					if (len_rdata != 17'd0)
						res_payload <= (pay_w > 35'hFFFFF) ? 20'hFFFFF : 20'(pay_w);
					res_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						res_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/bitmap_first_fit_block_allocator_core_tb.sv
//------------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core_tb: self-checking allocator testbench
// Runs a directed table and then a random mix of allocate, release and query
// commands with random stalls on both streams. A behavioral copy of the heap
// predicts each reply but a typed-in one; replies are checked in order.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module bitmap_first_fit_block_allocator_core_tb;
	import bffa_pkg::*;

	localparam int NBLK = 65536;
	localparam int BBYTES = 16;
	localparam longint HEAP = 64'(NBLK) * BBYTES;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1900;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] result_offset;
		logic [19:0] payload_bytes;
	} reply_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] size;
		logic [19:0] off;
		bit          typed;
		reply_t      want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	bitmap_first_fit_block_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Behavioral heap: used bit and stored run length per block.
	bit          block_used [NBLK];
	logic [16:0] block_run [NBLK];
	reply_t      pending_replies [$];
	int          errors = 0;
	bit          calm = 1'b0;	// when set, neither side starts a random stall

	// Computes the reply of one command and updates the heap copy.
	function automatic reply_t heap_apply(logic [1:0] op, logic [31:0] size, logic [19:0] off);
		reply_t r;
		longint need;
		longint first;
		longint end_blk;
		int     cnt;
		int     blk;
		bit     found;
		r = '0;
		found = 1'b0;
		first = 0;
		if (op == OP_ALLOC) begin
			if (size == 0 || 64'(size) + HDR_BYTES > HEAP) begin
				r.status = ST_BAD_SZ;
			end else begin
				need = (64'(size) + HDR_BYTES + BBYTES - 1) / BBYTES;
				cnt = 0;
				for (int i = 0; i < NBLK && !found; i++) begin
					if (!block_used[i]) begin
						if (cnt == 0) first = i;
						cnt++;
						if (cnt == need) found = 1'b1;
					end else begin
						cnt = 0;
					end
				end
				if (!found) begin
					r.status = ST_NO_RUN;
				end else begin
					for (longint i = first; i < first + need; i++) block_used[i] = 1'b1;
					block_run[first] = 17'(need);
					r.result_offset = 20'(first * BBYTES + HDR_BYTES);
				end
			end
		end else if (op == OP_FREE || op == OP_QUERY) begin
			if (off < HDR_BYTES || 64'(off) >= HEAP) begin
				r.status = ST_BAD_OFF;
			end else begin
				blk = (int'(off) - HDR_BYTES) / BBYTES;
				if (op == OP_FREE) begin
					end_blk = 64'(blk) + block_run[blk];
					if (end_blk > NBLK) end_blk = NBLK;
					for (longint i = blk; i < end_blk; i++) block_used[i] = 1'b0;
				end else if (block_run[blk] != 0) begin
					need = 64'(block_run[blk]) * BBYTES - HDR_BYTES;
					r.payload_bytes = need > 64'hFFFFF ? 20'hFFFFF : 20'(need);
				end
			end
		end else begin
			r.status = ST_BAD_OFF;
		end
		return r;
	endfunction

	// Offsets of allocations believed live, used to aim releases and queries.
	logic [19:0] live_offsets [$];

	// Sends one command, with a random gap in front unless in a calm stretch.
	// The reply is predicted at acceptance; a typed-in reply replaces it.
	task automatic send_cmd(logic [1:0] op, logic [31:0] size, logic [19:0] off,
			bit typed, reply_t want, output reply_t got);
		int gap;
		gap = 0;
		if (!calm) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = $urandom_range(1, 3);
				3:       gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : 1;
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, off, size, op};
		do @(posedge clk); while (!s_axis_tready);
		got = heap_apply(op, size, off);
		if (typed) got = want;
		pending_replies.push_back(got);
	endtask

	// Reply side: checks accepted replies and stalls at random.
	int stall_left = 0;
	always @(posedge clk) begin
		reply_t act;
		reply_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act.status        = m_axis_tdata[1:0];
			act.result_offset = m_axis_tdata[21:2];
			act.payload_bytes = m_axis_tdata[41:22];
			if (pending_replies.size() == 0) begin
				$error("reply with none expected: %h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (act.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, act.status);
					errors++;
				end
				if (act.result_offset !== exp_r.result_offset) begin
					$error("result_offset: expected %0d, got %0d",
						exp_r.result_offset, act.result_offset);
					errors++;
				end
				if (act.payload_bytes !== exp_r.payload_bytes) begin
					$error("payload_bytes: expected %0d, got %0d",
						exp_r.payload_bytes, act.payload_bytes);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 60)
				: $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#480_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	row_t   rows [27];
	reply_t got;
	reply_t none;

	function automatic row_t mk(logic [1:0] op, logic [31:0] size, logic [19:0] off,
			bit typed, logic [1:0] st, logic [19:0] ro, logic [19:0] pb);
		row_t r;
		r.op = op;
		r.size = size;
		r.off = off;
		r.typed = typed;
		r.want = '{st, ro, pb};
		return r;
	endfunction

	initial begin
		int     pick;
		int     kind;
		logic [19:0] o;
		for (int i = 0; i < NBLK; i++) begin
			block_used[i] = 1'b0;
			block_run[i] = '0;
		end
		none = '0;

		// Directed part: fresh heap, size and offset extremes, error codes,
		// stale length after release, unaligned offsets and the top block.
		rows[0]  = mk(OP_ALLOC, 1, 0, 1, ST_DONE, 4, 0);
		rows[1]  = mk(OP_ALLOC, 12, 0, 1, ST_DONE, 20, 0);
		rows[2]  = mk(OP_ALLOC, 13, 0, 1, ST_DONE, 36, 0);
		rows[3]  = mk(OP_QUERY, 0, 4, 1, ST_DONE, 0, 12);
		rows[4]  = mk(OP_QUERY, 0, 36, 1, ST_DONE, 0, 28);
		rows[5]  = mk(OP_QUERY, 0, 0, 1, ST_BAD_OFF, 0, 0);
		rows[6]  = mk(OP_QUERY, 32'hFFFF_FFFF, 3, 1, ST_BAD_OFF, 0, 0);
		rows[7]  = mk(OP_FREE, 0, 20'hFFFFF, 1, ST_DONE, 0, 0);
		rows[8]  = mk(OP_ALLOC, 0, 0, 1, ST_BAD_SZ, 0, 0);
		rows[9]  = mk(OP_ALLOC, 1048573, 0, 1, ST_BAD_SZ, 0, 0);
		rows[10] = mk(OP_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF, 1, ST_BAD_SZ, 0, 0);
		rows[11] = mk(OP_ALLOC, 1048572, 0, 1, ST_NO_RUN, 0, 0);
		rows[12] = mk(OP_UNUSED, 32'hFFFF_FFFF, 20'hFFFFF, 1, ST_BAD_OFF, 0, 0);
		rows[13] = mk(OP_FREE, 0, 25, 1, ST_DONE, 0, 0);
		rows[14] = mk(OP_FREE, 0, 20, 1, ST_DONE, 0, 0);
		rows[15] = mk(OP_QUERY, 0, 30, 1, ST_DONE, 0, 12);
		rows[16] = mk(OP_ALLOC, 5, 0, 1, ST_DONE, 20, 0);
		rows[17] = mk(OP_FREE, 0, 4, 0, 0, 0, 0);
		rows[18] = mk(OP_FREE, 0, 20, 0, 0, 0, 0);
		rows[19] = mk(OP_FREE, 0, 47, 0, 0, 0, 0);
		rows[20] = mk(OP_ALLOC, 1048572, 0, 1, ST_DONE, 4, 0);
		rows[21] = mk(OP_QUERY, 0, 4, 1, ST_DONE, 0, 1048572);
		rows[22] = mk(OP_FREE, 0, 4, 1, ST_DONE, 0, 0);
		rows[23] = mk(OP_ALLOC, 1048556, 0, 1, ST_DONE, 4, 0);
		rows[24] = mk(OP_ALLOC, 1, 0, 1, ST_DONE, 1048564, 0);
		rows[25] = mk(OP_FREE, 0, 4, 0, 0, 0, 0);
		rows[26] = mk(OP_FREE, 0, 1048564, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_cmd(rows[i].op, rows[i].size, rows[i].off, rows[i].typed, rows[i].want, got);

		// Random part: mostly small allocations and releases of live ones,
		// so scans stay short, plus queries, stale and unaligned offsets,
		// occasional huge requests and plain noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 250 == 0) calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (live_offsets.size() > 40 && kind < 45) kind = 50;
			if (kind < 45) begin
				send_cmd(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2000)
					: $urandom_range(1, 200), 0, 0, none, got);
				if (got.status == ST_DONE) live_offsets.push_back(got.result_offset);
			end else if (kind < 75 && live_offsets.size() > 0) begin
				pick = $urandom_range(0, live_offsets.size() - 1);
				o = live_offsets[pick];
				if ($urandom_range(0, 9) != 0) live_offsets.delete(pick);
				send_cmd(OP_FREE, $urandom, o + 20'($urandom_range(0, 11)), 0, none, got);
			end else if (kind < 90) begin
				o = (live_offsets.size() > 0 && $urandom_range(0, 2) != 0)
					? live_offsets[$urandom_range(0, live_offsets.size() - 1)]
					: 20'($urandom);
				send_cmd(OP_QUERY, $urandom, o, 0, none, got);
			end else if (kind < 92) begin
				// A huge block is released right away so later scans stay short.
				send_cmd(OP_ALLOC, $urandom_range(1, 1048572), 0, 0, none, got);
				if (got.status == ST_DONE)
					send_cmd(OP_FREE, 0, got.result_offset, 0, none, got);
			end else begin
				case ($urandom_range(0, 4))
					0: send_cmd(OP_ALLOC, $urandom | 32'h0010_0000, 20'($urandom), 0, none,
						got);
					1: send_cmd(OP_UNUSED, $urandom, 20'($urandom), 0, none, got);
					2: send_cmd(2'($urandom_range(1, 2)), $urandom,
						20'($urandom_range(0, 3)), 0, none, got);
					3: send_cmd(OP_ALLOC, 0, 20'($urandom), 0, none, got);
					default: send_cmd(OP_QUERY, $urandom, 20'($urandom), 0, none, got);
				endcase
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire
